[sv/dod_pkg.sv]
// Shared types and constants for the detection output decode block.
// No dependencies; imported by every module of the block.
package dod_pkg;

    // Input word operation codes
    localparam logic OP_COORD = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAD_X       = 3'd0,
        CFG_PAD_Y       = 3'd1,
        CFG_X_FACTOR    = 3'd2,
        CFG_Y_FACTOR    = 3'd3,
        CFG_THRESHOLD   = 3'd4,
        CFG_NUM_CLASSES = 3'd5
    } t_cfg_idx;

    localparam int CFG_DATA_W = 24;

    // Field widths
    localparam int CORNER_W = 16;
    localparam int SCORE_W  = 16;
    localparam int CLASS_W  = 7;
    localparam int PAD_W    = 10;
    localparam int FACTOR_W = 24;
    localparam int NCLS_W   = 8;
    localparam int BOX_W    = 17;

    // Fixed-point constants: corners are Q.5, result is Q0.16 from Q.5 * Q0.24
    localparam int PAD_SHIFT  = 5;
    localparam int NORM_SHIFT = 13;
    localparam int OFFSET_W   = CORNER_W + 1;
    localparam int MAG_W      = CORNER_W - 1;
    localparam int PROD_W     = MAG_W + FACTOR_W;
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W+1)'(1) << (NORM_SHIFT - 1);
    localparam logic [BOX_W-1:0]  NORM_ONE   = BOX_W'(65536);

    // Register reset values
    localparam logic [PAD_W-1:0]    RST_PAD       = '0;
    localparam logic [FACTOR_W-1:0] RST_FACTOR    = FACTOR_W'(1677);
    localparam logic [SCORE_W-1:0]  RST_THRESHOLD = SCORE_W'(32768);
    localparam logic [NCLS_W-1:0]   RST_NCLS      = NCLS_W'(80);

    // A candidate that has passed the argmax and the threshold
    typedef struct packed {
        logic [3:0][CORNER_W-1:0] corners;   // x1, y1, x2, y2
        logic [SCORE_W-1:0]       score;
        logic [CLASS_W-1:0]       cls;
    } t_cand;

endpackage

[sv/dod_argmax.sv]
// Running argmax over the class scores of one candidate, with corner hold.
// Depends on dod_pkg. Flags the word that completes a candidate worth emitting.
module dod_argmax #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_operation,
    input  logic [3:0][dod_pkg::CORNER_W-1:0] i_corners,
    input  logic [dod_pkg::SCORE_W-1:0]   i_class_score,
    input  logic [dod_pkg::NCLS_W-1:0]    i_num_classes,
    input  logic [dod_pkg::SCORE_W-1:0]   i_threshold,
    output logic                          o_emit,
    output dod_pkg::t_cand                o_cand
);
    import dod_pkg::*;

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int EXT_W = (CNT_W > NCLS_W) ? CNT_W : NCLS_W;

    logic [3:0][CORNER_W-1:0] r_corners;
    logic [SCORE_W-1:0]       r_best, n_best;
    logic [CLASS_W-1:0]       r_cls, n_cls;
    logic                     r_found, n_found;
    logic [CNT_W-1:0]         r_cnt, n_cnt;

    logic [EXT_W-1:0] ncls_ext;
    logic [CNT_W-1:0] n_eff;
    logic             active;
    logic             last;

    // Class count clamped to 1..MAX_CLASSES
    always_comb begin
        ncls_ext = EXT_W'(i_num_classes);
        if (ncls_ext == '0) begin
            n_eff = CNT_W'(1);
        end else if (ncls_ext > EXT_W'(MAX_CLASSES)) begin
            n_eff = CNT_W'(MAX_CLASSES);
        end else begin
            n_eff = ncls_ext[CNT_W-1:0];
        end
    end

    always_comb begin
        active  = (i_operation == OP_SCORE) && (r_cnt < n_eff);
        n_best  = r_best;
        n_cls   = r_cls;
        n_found = r_found;
        n_cnt   = r_cnt;
        if (active) begin
            if (i_class_score > r_best) begin
                n_best  = i_class_score;
                n_cls   = CLASS_W'(r_cnt);
                n_found = 1'b1;
            end
            n_cnt = r_cnt + CNT_W'(1);
        end
        last   = active && (n_cnt == n_eff);
        o_emit = last && n_found && (n_best >= i_threshold);

        o_cand.corners = r_corners;
        o_cand.score   = n_best;
        o_cand.cls     = n_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corners <= '0;
            r_best    <= '0;
            r_cls     <= '0;
            r_found   <= 1'b0;
            r_cnt     <= '0;
        end else if (i_accept) begin
            if (i_operation == OP_COORD) begin
                r_corners <= i_corners;
                r_best    <= '0;
                r_cls     <= '0;
                r_found   <= 1'b0;
                r_cnt     <= '0;
            end else begin
                r_best  <= n_best;
                r_cls   <= n_cls;
                r_found <= n_found;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

[sv/dod_norm.sv]
// One corner: remove letterbox pad, scale by the axis factor, round, clamp.
// Depends on dod_pkg. Pure combinational, one 15x24 multiply.
module dod_norm (
    input  logic [dod_pkg::CORNER_W-1:0] i_corner,
    input  logic [dod_pkg::PAD_W-1:0]    i_pad,
    input  logic [dod_pkg::FACTOR_W-1:0] i_factor,
    output logic [dod_pkg::BOX_W-1:0]    o_box
);
    import dod_pkg::*;

    logic signed [OFFSET_W-1:0] offset;
    logic [MAG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W:0]            rounded;
    logic [PROD_W-NORM_SHIFT:0] scaled;

    always_comb begin
        // Pad is whole pixels, corners Q.5; positive offsets never exceed 15 bits
        offset  = $signed({i_corner[CORNER_W-1], i_corner})
                - $signed(OFFSET_W'({i_pad, PAD_SHIFT'(0)}));
        mag     = offset[MAG_W-1:0];
        prod    = PROD_W'(mag) * PROD_W'(i_factor);
        rounded = {1'b0, prod} + ROUND_HALF;
        scaled  = rounded[PROD_W:NORM_SHIFT];
        if (offset <= 0) begin
            o_box = '0;
        end else if (scaled > (PROD_W-NORM_SHIFT+1)'(NORM_ONE)) begin
            o_box = NORM_ONE;
        end else begin
            o_box = scaled[BOX_W-1:0];
        end
    end

endmodule

[sv/detection_output_decode.sv]
// Detection output decode: argmax over class scores, then box normalisation.
// Takes one word per cycle while o_stall is low. The final score word of a candidate
// is registered in the candidate stage (argmax), then normalised by the multiply into
// the output register. Synchronous active-low reset clears candidate state and
// pipeline valids and loads the configuration registers with their default values.
module detection_output_decode #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dod_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dod_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input words
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_operation,
    input  logic signed [dod_pkg::CORNER_W-1:0] i_corner_x1,
    input  logic signed [dod_pkg::CORNER_W-1:0] i_corner_y1,
    input  logic signed [dod_pkg::CORNER_W-1:0] i_corner_x2,
    input  logic signed [dod_pkg::CORNER_W-1:0] i_corner_y2,
    input  logic [dod_pkg::SCORE_W-1:0]      i_class_score,
    // result words
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [dod_pkg::BOX_W-1:0]        o_box_x1,
    output logic [dod_pkg::BOX_W-1:0]        o_box_y1,
    output logic [dod_pkg::BOX_W-1:0]        o_box_x2,
    output logic [dod_pkg::BOX_W-1:0]        o_box_y2,
    output logic [dod_pkg::SCORE_W-1:0]      o_best_score,
    output logic [dod_pkg::CLASS_W-1:0]      o_best_class
);
    import dod_pkg::*;

    logic [PAD_W-1:0]    r_pad_x, r_pad_y;
    logic [FACTOR_W-1:0] r_x_factor, r_y_factor;
    logic [SCORE_W-1:0]  r_threshold;
    logic [NCLS_W-1:0]   r_num_classes;

    logic  r_s1_valid, n_s1_valid;
    t_cand r_s1;
    logic  r_out_valid, n_out_valid;
    logic [3:0][BOX_W-1:0] r_box;
    logic [SCORE_W-1:0]    r_score;
    logic [CLASS_W-1:0]    r_cls;

    logic  in_accept;
    logic  s2_load;
    logic  emit;
    t_cand cand;
    logic [3:0][BOX_W-1:0] norm_box;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_x       <= RST_PAD;
            r_pad_y       <= RST_PAD;
            r_x_factor    <= RST_FACTOR;
            r_y_factor    <= RST_FACTOR;
            r_threshold   <= RST_THRESHOLD;
            r_num_classes <= RST_NCLS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PAD_X:       r_pad_x       <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_Y:       r_pad_y       <= i_cfg_data[PAD_W-1:0];
                CFG_X_FACTOR:    r_x_factor    <= i_cfg_data[FACTOR_W-1:0];
                CFG_Y_FACTOR:    r_y_factor    <= i_cfg_data[FACTOR_W-1:0];
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[SCORE_W-1:0];
                CFG_NUM_CLASSES: r_num_classes <= i_cfg_data[NCLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the output register frees the candidate stage, which frees input
    assign s2_load   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !s2_load;
    assign in_accept = i_valid && !o_stall;

    dod_argmax #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_argmax (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_operation   (i_operation),
        .i_corners     ({i_corner_y2, i_corner_x2, i_corner_y1, i_corner_x1}),
        .i_class_score (i_class_score),
        .i_num_classes (r_num_classes),
        .i_threshold   (r_threshold),
        .o_emit        (emit),
        .o_cand        (cand)
    );

    // corners[0..3] = x1, y1, x2, y2; even ones are x
    for (genvar g = 0; g < 4; g++) begin : g_norm
        dod_norm u_norm (
            .i_corner (r_s1.corners[g]),
            .i_pad    ((g % 2 == 0) ? r_pad_x : r_pad_y),
            .i_factor ((g % 2 == 0) ? r_x_factor : r_y_factor),
            .o_box    (norm_box[g])
        );
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept && emit) begin
            n_s1_valid = 1'b1;
        end else if (s2_load) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s2_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_s1 <= cand;
        end
        if (s2_load) begin
            r_box   <= norm_box;
            r_score <= r_s1.score;
            r_cls   <= r_s1.cls;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_box_x1     = r_box[0];
    assign o_box_y1     = r_box[1];
    assign o_box_x2     = r_box[2];
    assign o_box_y2     = r_box[3];
    assign o_best_score = r_score;
    assign o_best_class = r_cls;

`ifndef NO_ASSERTIONS
    a_emit_on_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && emit) |-> (i_operation == OP_SCORE))
        else $error("candidate completed by a coordinate word");

    a_score_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_best_score >= r_threshold && o_best_score != '0))
        else $error("result below threshold or without a winning class");

    a_box_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box_x1 <= NORM_ONE && o_box_y1 <= NORM_ONE &&
                     o_box_x2 <= NORM_ONE && o_box_y2 <= NORM_ONE))
        else $error("box coordinate above one");

    a_cand_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_load) |=> (r_s1_valid && $stable(r_s1)))
        else $error("pending candidate lost while output stalled");
`endif

endmodule

[tb/detection_output_decode_test.sv]
// Self-checking testbench for detection_output_decode: argmax, threshold and box scaling.
// Depends on dod_pkg and the block itself; a queue-fed driver and a clocked monitor check
// every result word against a built-in prediction of the block.
module detection_output_decode_test;
    import dod_pkg::*;

    localparam int CLASS_LIMIT = 128;
    localparam int WORD_TARGET = 900;

    typedef struct {
        logic                op;
        logic [CORNER_W-1:0] x1, y1, x2, y2;
        logic [SCORE_W-1:0]  score;
    } t_word;

    typedef struct {
        logic [BOX_W-1:0]   x1, y1, x2, y2;
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] cls;
    } t_box;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_operation = OP_COORD;
    logic [CORNER_W-1:0]   i_corner_x1 = '0;
    logic [CORNER_W-1:0]   i_corner_y1 = '0;
    logic [CORNER_W-1:0]   i_corner_x2 = '0;
    logic [CORNER_W-1:0]   i_corner_y2 = '0;
    logic [SCORE_W-1:0]    i_class_score = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [BOX_W-1:0]      o_box_x1, o_box_y1, o_box_x2, o_box_y2;
    logic [SCORE_W-1:0]    o_best_score;
    logic [CLASS_W-1:0]    o_best_class;

    detection_output_decode i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_corner_x1   (i_corner_x1),
        .i_corner_y1   (i_corner_y1),
        .i_corner_x2   (i_corner_x2),
        .i_corner_y2   (i_corner_y2),
        .i_class_score (i_class_score),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_box_x1      (o_box_x1),
        .o_box_y1      (o_box_y1),
        .o_box_x2      (o_box_x2),
        .o_box_y2      (o_box_y2),
        .o_best_score  (o_best_score),
        .o_best_class  (o_best_class)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register copies, updated as each write is accepted
    logic [PAD_W-1:0]    cfg_pad_x = RST_PAD;
    logic [PAD_W-1:0]    cfg_pad_y = RST_PAD;
    logic [FACTOR_W-1:0] cfg_x_factor = RST_FACTOR;
    logic [FACTOR_W-1:0] cfg_y_factor = RST_FACTOR;
    logic [SCORE_W-1:0]  cfg_threshold = RST_THRESHOLD;
    logic [NCLS_W-1:0]   cfg_num_classes = RST_NCLS;

    // candidate state of the prediction
    logic signed [CORNER_W-1:0] held_corner [4];
    logic [SCORE_W-1:0]         lead_score = '0;
    int                         lead_class = 0;
    bit                         lead_found = 1'b0;
    int                         scores_seen = 0;

    t_word pending_words [$];
    t_box  pending_boxes [$];
    t_box  want;
    int    words_made = 0;
    int    fail_count = 0;
    int    word_gap = 0;
    int    stall_gap = 0;
    bit    word_taken = 1'b0;
    bit    quiet = 1'b0;

    initial foreach (held_corner[k]) held_corner[k] = '0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
        fail_count++;
    endtask

    function automatic int active_classes();
        if (cfg_num_classes == 0) return 1;
        if (cfg_num_classes > CLASS_LIMIT) return CLASS_LIMIT;
        return int'(cfg_num_classes);
    endfunction

    // corner minus pad (Q.5), times Q0.24 factor, rounded to Q0.16 and clamped to 1.0
    function automatic logic [BOX_W-1:0] box_offset(input logic signed [CORNER_W-1:0] c,
                                                    input logic [PAD_W-1:0] pad,
                                                    input logic [FACTOR_W-1:0] f);
        longint off, v;
        off = longint'(c) - longint'(pad) * 32;
        if (off <= 0) return '0;
        v = (off * longint'(f) + 4096) >>> 13;
        if (v > 65536) return BOX_W'(65536);
        return v[BOX_W-1:0];
    endfunction

    task automatic absorb_word(input t_word w);
        int   n;
        t_box b;
        n = active_classes();
        if (w.op == OP_COORD) begin
            held_corner[0] = w.x1;
            held_corner[1] = w.y1;
            held_corner[2] = w.x2;
            held_corner[3] = w.y2;
            lead_score  = '0;
            lead_class  = 0;
            lead_found  = 1'b0;
            scores_seen = 0;
        end else if (scores_seen < n) begin
            if (w.score > lead_score) begin
                lead_score = w.score;
                lead_class = scores_seen;
                lead_found = 1'b1;
            end
            scores_seen++;
            if (scores_seen == n && lead_found && lead_score >= cfg_threshold) begin
                b.x1    = box_offset(held_corner[0], cfg_pad_x, cfg_x_factor);
                b.y1    = box_offset(held_corner[1], cfg_pad_y, cfg_y_factor);
                b.x2    = box_offset(held_corner[2], cfg_pad_x, cfg_x_factor);
                b.y2    = box_offset(held_corner[3], cfg_pad_y, cfg_y_factor);
                b.score = lead_score;
                b.cls   = CLASS_W'(lead_class);
                pending_boxes = {pending_boxes, b};
            end
        end
    endtask

    function automatic int draw_gap();
        if (quiet) return 0;
        return $urandom_range(0, 9);
    endfunction

    // input side: words change on the falling edge, acceptance seen on the rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && (word_taken || !i_valid)) begin
            word_taken = 1'b0;
            if (word_gap > 0) begin
                word_gap--;
                i_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_operation   <= pending_words[0].op;
                i_corner_x1   <= pending_words[0].x1;
                i_corner_y1   <= pending_words[0].y1;
                i_corner_x2   <= pending_words[0].x2;
                i_corner_y2   <= pending_words[0].y2;
                i_class_score <= pending_words[0].score;
                i_valid       <= 1'b1;
                word_gap = draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            absorb_word(pending_words.pop_front());
            word_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (stall_gap > 0) begin
            stall_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_boxes.size() == 0) begin
                report_mismatch("unexpected box, score", 32'(o_best_score), 0);
            end else begin
                want = pending_boxes.pop_front();
                if (o_box_x1 !== want.x1)
                    report_mismatch("box_x1", 32'(o_box_x1), 32'(want.x1));
                if (o_box_y1 !== want.y1)
                    report_mismatch("box_y1", 32'(o_box_y1), 32'(want.y1));
                if (o_box_x2 !== want.x2)
                    report_mismatch("box_x2", 32'(o_box_x2), 32'(want.x2));
                if (o_box_y2 !== want.y2)
                    report_mismatch("box_y2", 32'(o_box_y2), 32'(want.y2));
                if (o_best_score !== want.score)
                    report_mismatch("best_score", 32'(o_best_score), 32'(want.score));
                if (o_best_class !== want.cls)
                    report_mismatch("best_class", 32'(o_best_class), 32'(want.cls));
            end
            stall_gap = draw_gap();
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PAD_X:       cfg_pad_x       = data[PAD_W-1:0];
            CFG_PAD_Y:       cfg_pad_y       = data[PAD_W-1:0];
            CFG_X_FACTOR:    cfg_x_factor    = data[FACTOR_W-1:0];
            CFG_Y_FACTOR:    cfg_y_factor    = data[FACTOR_W-1:0];
            CFG_THRESHOLD:   cfg_threshold   = data[SCORE_W-1:0];
            CFG_NUM_CLASSES: cfg_num_classes = data[NCLS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // coordinate words may still be in flight with nothing expected, hence the tail
    task automatic wait_idle();
        while (pending_words.size() != 0 || pending_boxes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_coord(input logic [CORNER_W-1:0] x1, y1, x2, y2);
        t_word w;
        w.op    = OP_COORD;
        w.x1    = x1;
        w.y1    = y1;
        w.x2    = x2;
        w.y2    = y2;
        w.score = SCORE_W'($urandom);
        pending_words = {pending_words, w};
        words_made++;
    endtask

    task automatic push_score(input logic [SCORE_W-1:0] s, input bit counts);
        t_word w;
        w.op    = OP_SCORE;
        w.x1    = CORNER_W'($urandom);
        w.y1    = CORNER_W'($urandom);
        w.x2    = CORNER_W'($urandom);
        w.y2    = CORNER_W'($urandom);
        w.score = s;
        pending_words = {pending_words, w};
        if (counts) words_made++;
    endtask

    function automatic logic [CORNER_W-1:0] draw_corner(input logic [PAD_W-1:0] pad);
        int v;
        case ($urandom_range(0, 7))
            0:       v = $urandom;
            1:       v = pad * 32;
            2:       v = pad * 32 - $urandom_range(1, 64);
            3:       v = 32'h7FFF;
            4:       v = 32'h8000;
            default: v = pad * 32 + $urandom_range(0, 20479);
        endcase
        return v[CORNER_W-1:0];
    endfunction

    function automatic logic [SCORE_W-1:0] draw_score(input logic [SCORE_W-1:0] prev);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return prev;
            3:       return cfg_threshold;
            4:       return cfg_threshold - 1'b1;
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick4(input logic [CFG_DATA_W-1:0] a, b, c, d);
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return d;
        endcase
    endfunction

    // a ramp of rising scores makes the last class win
    task automatic add_candidate(input int n, input int cut, input bit ramp);
        logic [SCORE_W-1:0] prev, s;
        push_coord(draw_corner(cfg_pad_x), draw_corner(cfg_pad_y),
                   draw_corner(cfg_pad_x), draw_corner(cfg_pad_y));
        prev = SCORE_W'($urandom);
        for (int i = 0; i < cut; i++) begin
            s = ramp ? SCORE_W'(i * 500 + 1) : draw_score(prev);
            push_score(s, i < n);
            prev = s;
        end
    endtask

    task automatic random_settings(input int phase);
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_PAD_X,
                      pick4(0, 640, 1023, CFG_DATA_W'($urandom_range(0, 640))));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_PAD_Y,
                      pick4(0, 640, 1023, CFG_DATA_W'($urandom_range(0, 640))));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_X_FACTOR, pick4(0, 24'hFFFFFF, 26214,
                                          CFG_DATA_W'($urandom_range(0, 24'hFFFFFF))));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_Y_FACTOR, pick4(0, 24'hFFFFFF, 26214,
                                          CFG_DATA_W'($urandom_range(0, 24'hFFFFFF))));
        if (phase == 2)
            write_reg(CFG_THRESHOLD, 1000);
        else if ($urandom_range(0, 3) != 0)
            write_reg(CFG_THRESHOLD,
                      pick4(0, 65535, 32768, CFG_DATA_W'($urandom_range(0, 65535))));
        if (phase == 2)
            write_reg(CFG_NUM_CLASSES, CLASS_LIMIT);
        else if (phase == 6)
            write_reg(CFG_NUM_CLASSES, 255);
        else if ($urandom_range(0, 3) != 0)
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_NUM_CLASSES, 0);
                1:       write_reg(CFG_NUM_CLASSES, CFG_DATA_W'($urandom_range(10, 20)));
                default: write_reg(CFG_NUM_CLASSES, CFG_DATA_W'($urandom_range(1, 6)));
            endcase
    endtask

    // a phase may end part way through a candidate; the next one carries on with it
    task automatic random_phase(input int phase);
        int n, cands, cut, shape;
        wait_idle();
        quiet = ($urandom_range(0, 3) == 0);
        random_settings(phase);
        n = active_classes();
        cands = (n >= CLASS_LIMIT) ? 2 : $urandom_range(3, 15);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) push_score(draw_score('0), 1'b1);
        for (int c = 0; c < cands; c++) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) cut = $urandom_range(0, n - 1);
            else if (shape == 1) cut = n + $urandom_range(1, 3);
            else cut = n;
            add_candidate(n, cut, (n >= CLASS_LIMIT) && c == 0);
        end
    endtask

    initial begin
        int phase;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // scores straight after reset use all-zero corners
        write_reg(CFG_NUM_CLASSES, 2);
        push_score(40000, 1'b1);
        push_score(50000, 1'b1);
        push_score(16'hFFFF, 1'b0);
        push_coord(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001);
        push_score(16'hFFFF, 1'b1);
        push_score(16'hFFFF, 1'b1);
        push_coord(16'h0400, 16'h0800, 16'h1000, 16'h2000);
        push_score(0, 1'b1);
        push_score(0, 1'b1);
        push_coord(16'h0100, 16'h0200, 16'h3000, 16'h3800);
        push_score(32767, 1'b1);
        push_score(100, 1'b1);
        push_coord(16'hFFFF, 16'h0020, 16'h5000, 16'h6000);
        push_score(0, 1'b1);
        push_score(32768, 1'b1);
        wait_idle();

        // zero class count acts as one; zero threshold still needs a non-zero score
        write_reg(CFG_PAD_X, 640);
        write_reg(CFG_PAD_Y, 1023);
        write_reg(CFG_X_FACTOR, 24'hFFFFFF);
        write_reg(CFG_Y_FACTOR, 0);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_NUM_CLASSES, 0);
        push_coord(16'd20480, 16'h7FFF, 16'h7FFF, 16'd32737);
        push_score(1, 1'b1);
        push_coord(16'd20481, 16'h0000, 16'h6000, 16'h7FE0);
        push_score(0, 1'b1);
        push_score(7, 1'b0);

        phase = 0;
        while (words_made < WORD_TARGET) begin
            random_phase(phase);
            phase++;
        end
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
